### src/sqmr_pkg.sv
package sqmr_pkg;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 4;
    localparam int TURN_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Default largest matrix side
    localparam int MAX_SIZE_DEF = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TURNS = 1'd1;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] SIZE_RESET  = 4'd8;
    localparam logic [TURN_W-1:0] TURNS_RESET = 2'd0;

    // Clockwise quarter-turn codes
    localparam logic [TURN_W-1:0] TURN_0 = 2'd0;
    localparam logic [TURN_W-1:0] TURN_1 = 2'd1;
    localparam logic [TURN_W-1:0] TURN_2 = 2'd2;
    localparam logic [TURN_W-1:0] TURN_3 = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_last;
    } t_ctrl_cmd;

endpackage

### src/sqmr_in_if.sv
interface sqmr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sqmr_pkg::DATA_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

### src/sqmr_out_if.sv
interface sqmr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sqmr_pkg::DATA_W-1:0] rotated_value;
    logic                                last_of_run;

    modport source (output valid, output rotated_value, output last_of_run, input ready);
    modport sink   (input valid, input rotated_value, input last_of_run, output ready);
endinterface

### src/sqmr_ctrl.sv
module sqmr_ctrl #(
    parameter int MAX_SIZE = sqmr_pkg::MAX_SIZE_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [sqmr_pkg::SIZE_W-1:0]                i_cfg_size,
    input  logic [sqmr_pkg::TURN_W-1:0]                i_cfg_turns,
    input  logic                                       i_stall,
    output sqmr_pkg::t_ctrl_cmd                        o_cmd,
    output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] o_wr_addr,
    output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]          o_rd_row,
    output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]          o_rd_col,
    output logic [sqmr_pkg::SIZE_W-1:0]                o_size,
    output logic [sqmr_pkg::TURN_W-1:0]                o_turns
);

    localparam int SW  = sqmr_pkg::SIZE_W;
    localparam int TW  = 2 * SW;
    localparam int AW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int CW  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int LCW = $clog2(MAX_SIZE * MAX_SIZE + 1);

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                           r_state, n_state;
    logic [LCW-1:0]                 r_load_cnt, n_load_cnt;
    logic [CW-1:0]                  r_row, n_row;
    logic [CW-1:0]                  r_col, n_col;
    logic [SW-1:0]                  r_size, n_size;
    logic [sqmr_pkg::TURN_W-1:0]    r_turns, n_turns;

    logic [SW-1:0]  sz;
    logic [TW-1:0]  total;
    logic           wrap;
    logic [LCW-1:0] base;
    logic [LCW-1:0] cnt_next;
    logic           load_done;
    logic           accept;
    logic [SW-1:0]  size_m1;
    logic [CW-1:0]  last_idx;
    logic           row_end;
    logic           col_end;

    // Clamp the configured size to 1..MAX_SIZE
    always_comb begin
        priority if (i_cfg_size == '0) begin
            sz = SW'(1);
        end else if (i_cfg_size > SW'(MAX_SIZE)) begin
            sz = SW'(MAX_SIZE);
        end else begin
            sz = i_cfg_size;
        end
    end

    // Load bookkeeping: restart at entry 0 if the count is already past the end
    assign total     = TW'(sz) * TW'(sz);
    assign wrap      = TW'(r_load_cnt) >= total;
    assign base      = wrap ? '0 : r_load_cnt;
    assign cnt_next  = base + LCW'(1);
    assign load_done = TW'(cnt_next) == total;
    assign accept    = i_in_valid && (r_state == ST_LOAD);

    // Emission scan limits
    assign size_m1  = r_size - SW'(1);
    assign last_idx = size_m1[CW-1:0];
    assign col_end  = r_col == last_idx;
    assign row_end  = r_row == last_idx;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_row      = r_row;
        n_col      = r_col;
        n_size     = r_size;
        n_turns    = r_turns;
        o_cmd      = '0;

        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    o_cmd.wr_en = 1'b1;
                    if (load_done) begin
                        n_load_cnt = '0;
                        n_row      = '0;
                        n_col      = '0;
                        n_size     = sz;
                        n_turns    = i_cfg_turns;
                        n_state    = ST_EMIT;
                    end else begin
                        n_load_cnt = cnt_next;
                    end
                end
            end
            ST_EMIT: begin
                // Issue one store read per cycle while the output moves
                if (!i_stall) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_last = row_end && col_end;
                    if (col_end) begin
                        n_col = '0;
                        if (row_end) begin
                            n_state = ST_LOAD;
                        end else begin
                            n_row = r_row + CW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
        end
    end

    // Scan position and latched geometry
    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_size  <= n_size;
        r_turns <= n_turns;
    end

    assign o_in_ready = r_state == ST_LOAD;
    assign o_wr_addr  = base[AW-1:0];
    assign o_rd_row   = r_row;
    assign o_rd_col   = r_col;
    assign o_size     = r_size;
    assign o_turns    = r_turns;

endmodule

### src/sqmr_datapath.sv
module sqmr_datapath #(
    parameter int MAX_SIZE = sqmr_pkg::MAX_SIZE_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  sqmr_pkg::t_ctrl_cmd                        i_cmd,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] i_wr_addr,
    input  logic signed [sqmr_pkg::DATA_W-1:0]         i_wr_data,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]          i_rd_row,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]          i_rd_col,
    input  logic [sqmr_pkg::SIZE_W-1:0]                i_size,
    input  logic [sqmr_pkg::TURN_W-1:0]                i_turns,
    input  logic                                       i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [sqmr_pkg::DATA_W-1:0]         o_out_data,
    output logic                                       o_out_last,
    output logic                                       o_stall
);

    localparam int SW    = sqmr_pkg::SIZE_W;
    localparam int DW    = sqmr_pkg::DATA_W;
    localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int PW    = CW + SW + 1;

    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_rd_data;
    logic                 r_rd_last;
    logic                 r_rd_vld;
    logic signed [DW-1:0] r_out_data;
    logic                 r_out_last;
    logic                 r_out_vld;

    logic [SW-1:0] size_m1;
    logic [CW-1:0] last_idx;
    logic [CW-1:0] src_row;
    logic [CW-1:0] src_col;
    logic [PW-1:0] src_full;
    logic [AW-1:0] rd_addr;
    logic          stall;

    // Map output position to source position for the turn count
    assign size_m1  = i_size - SW'(1);
    assign last_idx = size_m1[CW-1:0];

    always_comb begin
        unique case (i_turns)
            sqmr_pkg::TURN_1: begin
                src_row = last_idx - i_rd_col;
                src_col = i_rd_row;
            end
            sqmr_pkg::TURN_2: begin
                src_row = last_idx - i_rd_row;
                src_col = last_idx - i_rd_col;
            end
            sqmr_pkg::TURN_3: begin
                src_row = i_rd_col;
                src_col = last_idx - i_rd_row;
            end
            default: begin
                src_row = i_rd_row;
                src_col = i_rd_col;
            end
        endcase
    end

    assign src_full = PW'(src_row) * PW'(i_size) + PW'(src_col);
    assign rd_addr  = src_full[AW-1:0];

    // Hold the whole read pipe while the output beat waits
    assign stall = r_out_vld && !i_out_ready;

    // Element store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_last <= i_cmd.rd_last;
        end
    end

    // Pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (!stall) begin
            r_rd_vld  <= i_cmd.rd_en;
            r_out_vld <= r_rd_vld;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_out_data <= r_rd_data;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_stall     = stall;

endmodule

### src/square_matrix_quarter_rotate.sv
// Square matrix quarter-turn rotator.
// i_elem carries matrix elements in row-major order, one beat per element;
// o_rot returns the rotated matrix in row-major order with last_of_run set
// on its final beat. Both channels use a valid/ready handshake.
// The i_cfg port writes matrix_size (index 0, 1..MAX_SIZE, 0 acts as 1 and
// larger values as MAX_SIZE) and quarter_turns (index 1, clockwise turns).
// Loading takes one element per cycle. After the final element of a matrix
// the result beats follow, one beat per cycle while the receiver does not
// stall, size*size beats in all, each read from the element store through a
// remapped address and passed through the store read register and the output
// register. i_elem.ready stays low while store reads are issued; the next
// matrix load overlaps the last two output beats.
// When the receiver stalls, the output register and the store read stage
// hold and no further reads are issued.
// Reset clears the load count and sets matrix_size to 8 and quarter_turns
// to 0; store contents are undefined until loaded.
module square_matrix_quarter_rotate #(
    parameter int MAX_SIZE = sqmr_pkg::MAX_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sqmr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sqmr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sqmr_in_if.sink                             i_elem,
    sqmr_out_if.source                          o_rot
);

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;
    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    logic [sqmr_pkg::SIZE_W-1:0] r_cfg_size;
    logic [sqmr_pkg::TURN_W-1:0] r_cfg_turns;

    sqmr_pkg::t_ctrl_cmd         cmd;
    logic [AW-1:0]               wr_addr;
    logic [CW-1:0]               rd_row;
    logic [CW-1:0]               rd_col;
    logic [sqmr_pkg::SIZE_W-1:0] emit_size;
    logic [sqmr_pkg::TURN_W-1:0] emit_turns;
    logic                        stall;
    logic                        in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size  <= sqmr_pkg::SIZE_RESET;
            r_cfg_turns <= sqmr_pkg::TURNS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqmr_pkg::REG_MATRIX_SIZE: begin
                    r_cfg_size <= i_cfg_data[sqmr_pkg::SIZE_W-1:0];
                end
                sqmr_pkg::REG_QUARTER_TURNS: begin
                    r_cfg_turns <= i_cfg_data[sqmr_pkg::TURN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sqmr_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_elem.valid),
        .o_in_ready  (in_ready),
        .i_cfg_size  (r_cfg_size),
        .i_cfg_turns (r_cfg_turns),
        .i_stall     (stall),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_row    (rd_row),
        .o_rd_col    (rd_col),
        .o_size      (emit_size),
        .o_turns     (emit_turns)
    );

    sqmr_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_elem.element_value),
        .i_rd_row    (rd_row),
        .i_rd_col    (rd_col),
        .i_size      (emit_size),
        .i_turns     (emit_turns),
        .i_out_ready (o_rot.ready),
        .o_out_valid (o_rot.valid),
        .o_out_data  (o_rot.rotated_value),
        .o_out_last  (o_rot.last_of_run),
        .o_stall     (stall)
    );

    assign i_elem.ready = in_ready;

endmodule
